[hdl/nnc_pkg.sv]
// ============================================================================
// nnc_pkg: shared types and constants for the nearest-neighbour classifier
// Opcodes, fixed result widths, controller states and the lane control struct.
// ============================================================================
package nnc_pkg;

    localparam int OPC_BITS      = 2;
    localparam int LABEL_BITS    = 2;
    localparam int NUM_FEATURES  = 4;
    localparam int OUT_DIST_BITS = 18;
    localparam int COUNT_BITS    = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [OPC_BITS-1:0] {
        OP_LOAD     = 2'd0,
        OP_CLASSIFY = 2'd1,
        OP_CLEAR    = 2'd2
    } t_opcode;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_MERGE,
        S_DONE
    } t_state;

    // per-cycle control broadcast to every lane
    typedef struct packed {
        logic clear;   // drop lane minimum, new query
        logic rd_en;   // read one row this cycle
    } t_scan_ctl;

endpackage

[hdl/nnc_ram.sv]
// ============================================================================
// nnc_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module nnc_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/nnc_lane.sv]
// ============================================================================
// nnc_lane: one search lane
// Holds every LANES-th sample in its own RAM bank and tracks the nearest
// one of its bank: read, square differences, sum and compare.
// ============================================================================
module nnc_lane #(
    parameter int FEATURE_BITS = 8,
    parameter int LANE_BITS    = 2,
    parameter int LANE_ID      = 0,
    parameter int ROW_DEPTH    = 16,
    parameter int ROW_BITS     = 4,
    parameter int CNT_BITS     = 7
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  nnc_pkg::t_scan_ctl                           i_ctl,
    input  logic [ROW_BITS-1:0]                          i_rd_row,
    input  logic [CNT_BITS-1:0]                          i_count,
    input  logic [nnc_pkg::NUM_FEATURES-1:0][FEATURE_BITS-1:0] i_query,
    input  logic                                         i_wr_en,
    input  logic [ROW_BITS-1:0]                          i_wr_row,
    input  logic [nnc_pkg::LABEL_BITS+nnc_pkg::NUM_FEATURES*FEATURE_BITS-1:0] i_wr_data,
    output logic                                         o_found,
    output logic [2*FEATURE_BITS+1:0]                    o_dist,
    output logic [ROW_BITS-1:0]                          o_row,
    output logic [nnc_pkg::LABEL_BITS-1:0]               o_label
);

    localparam int NF        = nnc_pkg::NUM_FEATURES;
    localparam int LB        = nnc_pkg::LABEL_BITS;
    localparam int WORD_BITS = LB + NF * FEATURE_BITS;
    localparam int SQ_BITS   = 2 * FEATURE_BITS;
    localparam int DIST_BITS = 2 * FEATURE_BITS + 2;
    localparam int CMP_BITS  = ROW_BITS + LANE_BITS + CNT_BITS;

    logic [WORD_BITS-1:0] rd_word;
    logic [CMP_BITS-1:0]  ent_idx;
    logic                 ent_valid;

    // stage 1: RAM output
    logic                 r_v1;
    logic [ROW_BITS-1:0]  r_row1;
    // stage 2: squared differences
    logic                 r_v2;
    logic [ROW_BITS-1:0]  r_row2;
    logic [LB-1:0]        r_lbl2;
    logic [NF-1:0][SQ_BITS-1:0] r_sq;
    // lane minimum
    logic                 r_found;
    logic [DIST_BITS-1:0] r_best;
    logic [ROW_BITS-1:0]  r_best_row;
    logic [LB-1:0]        r_best_lbl;

    logic [NF-1:0][SQ_BITS-1:0] n_sq;
    logic [DIST_BITS-1:0]       sum;
    logic                       take;

    nnc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROW_DEPTH)
    ) u_bank (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_row),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_ctl.rd_en),
        .i_rd_addr (i_rd_row),
        .o_rd_data (rd_word)
    );

    // global sample index of this row in this lane, checked against the fill
    assign ent_idx   = CMP_BITS'({i_rd_row, LANE_BITS'(LANE_ID)});
    assign ent_valid = i_ctl.rd_en && (ent_idx < CMP_BITS'(i_count));

    always_comb begin
        logic [FEATURE_BITS-1:0] s;
        logic [FEATURE_BITS-1:0] diff;
        for (int f = 0; f < NF; f++) begin
            s    = rd_word[f*FEATURE_BITS +: FEATURE_BITS];
            diff = (i_query[f] > s) ? (i_query[f] - s) : (s - i_query[f]);
            n_sq[f] = SQ_BITS'(diff) * SQ_BITS'(diff);
        end
    end

    assign sum = DIST_BITS'(r_sq[0]) + DIST_BITS'(r_sq[1])
               + DIST_BITS'(r_sq[2]) + DIST_BITS'(r_sq[3]);
    // strict less keeps the earliest row on ties
    assign take = r_v2 && (!r_found || (sum < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_v1 <= ent_valid;
            r_v2 <= r_v1;
            if (i_ctl.clear) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
        r_row1 <= i_rd_row;
        r_row2 <= r_row1;
        r_lbl2 <= rd_word[NF*FEATURE_BITS +: LB];
        r_sq   <= n_sq;
        if (take) begin
            r_best     <= sum;
            r_best_row <= r_row2;
            r_best_lbl <= r_lbl2;
        end
    end

    assign o_found = r_found;
    assign o_dist  = r_best;
    assign o_row   = r_best_row;
    assign o_label = r_best_lbl;

endmodule

[hdl/nnc_merge.sv]
// ============================================================================
// nnc_merge: lane merge
// Walks the lane minima one lane per cycle and keeps the nearest; ties go
// to the lower sample index (lower row, then lower lane).
// ============================================================================
module nnc_merge #(
    parameter int FEATURE_BITS = 8,
    parameter int LANE_BITS    = 2,
    parameter int ROW_BITS     = 4
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_start,
    input  logic [(1<<LANE_BITS)-1:0]                        i_found,
    input  logic [(1<<LANE_BITS)-1:0][2*FEATURE_BITS+1:0]    i_dist,
    input  logic [(1<<LANE_BITS)-1:0][ROW_BITS-1:0]          i_row,
    input  logic [(1<<LANE_BITS)-1:0][nnc_pkg::LABEL_BITS-1:0] i_label,
    output logic                                             o_done,
    output logic [2*FEATURE_BITS+1:0]                        o_dist,
    output logic [nnc_pkg::LABEL_BITS-1:0]                   o_label
);

    localparam int LANES     = 1 << LANE_BITS;
    localparam int DIST_BITS = 2 * FEATURE_BITS + 2;

    logic                 r_busy;
    logic                 r_done;
    logic [LANE_BITS-1:0] r_idx;
    logic                 r_have;
    logic [DIST_BITS-1:0] r_dist;
    logic [ROW_BITS-1:0]  r_row;
    logic [nnc_pkg::LABEL_BITS-1:0] r_label;

    logic take;
    logic last;

    assign take = r_busy && i_found[r_idx]
               && (!r_have || (i_dist[r_idx] < r_dist)
                   || ((i_dist[r_idx] == r_dist) && (i_row[r_idx] < r_row)));
    assign last = (r_idx == LANE_BITS'(LANES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
            r_have <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_have <= 1'b0;
            end else if (r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
                if (take) begin
                    r_have <= 1'b1;
                end
            end
        end
        if (take) begin
            r_dist  <= i_dist[r_idx];
            r_row   <= i_row[r_idx];
            r_label <= i_label[r_idx];
        end
    end

    assign o_done  = r_done;
    assign o_dist  = r_dist;
    assign o_label = r_label;

endmodule

[hdl/nearest_neighbour_classifier_top.sv]
// ============================================================================
// nearest_neighbour_classifier_top: one-nearest-neighbour classifier
// Loads labelled 4-feature samples into a banked store and answers classify
// transactions with the label of the nearest sample (squared Euclidean
// distance), a hit flag and a saturating count of hits.
// ============================================================================
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+--------------------------------------------
//  request  | i_valid | o_ready | i_opcode, i_feature_a..d, i_label
//  result   | o_valid | i_ready | o_predicted_class, o_is_correct,
//           |         |         | o_store_empty, o_min_distance_sq,
//           |         |         | o_correct_total
//
//  Load, clear and unused-opcode transactions are carried out on acceptance
//  and leave the controller in S_IDLE. A classify steps through S_SCAN,
//  S_DRAIN, S_MERGE and S_DONE before its result is registered: one row read
//  per cycle in every lane bank, the drain of the lane pipeline, then a walk
//  over the lanes in the merge. With an empty store it goes straight to S_DONE.
//  A finished result waits in the output register while new load or clear
//  transactions are taken; a classify that finishes first holds in S_DONE.
//  Reset empties the store (fill count) and clears the hit counter; stored
//  samples need no clearing since only filled entries are ever compared.
//
module nearest_neighbour_classifier_top #(
    parameter int STORE_DEPTH  = 64,   // 1 .. 4096 samples
    parameter int FEATURE_BITS = 8,    // 4 .. 8 bits per feature
    parameter int LANE_BITS    = 2     // 1 .. 4, LANES = 2**LANE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [nnc_pkg::OPC_BITS-1:0]   i_opcode,
    input  logic [FEATURE_BITS-1:0] i_feature_a,
    input  logic [FEATURE_BITS-1:0] i_feature_b,
    input  logic [FEATURE_BITS-1:0] i_feature_c,
    input  logic [FEATURE_BITS-1:0] i_feature_d,
    input  logic [nnc_pkg::LABEL_BITS-1:0] i_label,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [nnc_pkg::LABEL_BITS-1:0]    o_predicted_class,
    output logic                              o_is_correct,
    output logic                              o_store_empty,
    output logic [nnc_pkg::OUT_DIST_BITS-1:0] o_min_distance_sq,
    output logic [nnc_pkg::COUNT_BITS-1:0]    o_correct_total
);

    localparam int LANES     = 1 << LANE_BITS;
    localparam int NF        = nnc_pkg::NUM_FEATURES;
    localparam int LB        = nnc_pkg::LABEL_BITS;
    localparam int DIST_BITS = 2 * FEATURE_BITS + 2;
    localparam int ROW_DEPTH = (STORE_DEPTH + LANES - 1) / LANES;
    localparam int ROW_BITS  = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(STORE_DEPTH + 1);
    localparam int IDX_BITS  = CNT_BITS + LANE_BITS + ROW_BITS;
    localparam int WORD_BITS = LB + NF * FEATURE_BITS;

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    nnc_pkg::t_state r_state, n_state;
    logic [CNT_BITS-1:0]            r_count;
    logic [nnc_pkg::COUNT_BITS-1:0] r_correct;
    logic [ROW_BITS-1:0]            r_row;
    logic [ROW_BITS-1:0]            r_last_row;
    logic                           r_drain;
    logic                           r_qempty;
    logic [LB-1:0]                  r_qlabel;
    logic [NF-1:0][FEATURE_BITS-1:0] r_query;

    // result register
    logic                               r_out_valid;
    logic [LB-1:0]                      r_pred;
    logic                               r_hit;
    logic                               r_empty;
    logic [nnc_pkg::OUT_DIST_BITS-1:0]  r_dist;
    logic [nnc_pkg::COUNT_BITS-1:0]     r_total;

    // decoded strobes
    logic               accept;
    logic               is_load, is_classify, is_clear;
    logic               store_full;
    logic               wr_en;
    logic [IDX_BITS-1:0] wr_idx;
    logic [IDX_BITS-1:0] last_idx;
    logic [ROW_BITS-1:0] wr_row;
    logic [LANE_BITS-1:0] wr_lane;
    logic [WORD_BITS-1:0] wr_word;

    nnc_pkg::t_scan_ctl scan_ctl;
    logic               merge_start;
    logic               merge_done;
    logic               ld_out;
    logic               out_free;

    // lane results
    logic [LANES-1:0]                lane_found;
    logic [LANES-1:0][DIST_BITS-1:0] lane_dist;
    logic [LANES-1:0][ROW_BITS-1:0]  lane_row;
    logic [LANES-1:0][LB-1:0]        lane_label;
    logic [DIST_BITS-1:0]            best_dist;
    logic [LB-1:0]                   best_label;

    logic                            hit;
    logic [DIST_BITS+nnc_pkg::OUT_DIST_BITS-1:0] dist_ext;

    assign accept      = i_valid && o_ready;
    assign is_load     = (i_opcode == nnc_pkg::OP_LOAD);
    assign is_classify = (i_opcode == nnc_pkg::OP_CLASSIFY);
    assign is_clear    = (i_opcode == nnc_pkg::OP_CLEAR);
    assign store_full  = (r_count >= CNT_BITS'(STORE_DEPTH));

    // sample n lives in lane n mod LANES, row n / LANES
    assign wr_idx   = IDX_BITS'(r_count);
    assign wr_lane  = wr_idx[LANE_BITS-1:0];
    assign wr_row   = wr_idx[LANE_BITS +: ROW_BITS];
    assign wr_en    = accept && is_load && !store_full;
    assign wr_word  = {i_label, i_feature_d, i_feature_c, i_feature_b, i_feature_a};
    assign last_idx = IDX_BITS'(r_count) - IDX_BITS'(1);

    assign out_free = !r_out_valid || i_ready;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nnc_pkg::S_IDLE: begin
                if (accept && is_classify) begin
                    n_state = (r_count == '0) ? nnc_pkg::S_DONE : nnc_pkg::S_SCAN;
                end
            end
            nnc_pkg::S_SCAN: begin
                if (r_row == r_last_row) begin
                    n_state = nnc_pkg::S_DRAIN;
                end
            end
            nnc_pkg::S_DRAIN: begin
                if (r_drain) begin
                    n_state = nnc_pkg::S_MERGE;
                end
            end
            nnc_pkg::S_MERGE: begin
                if (merge_done) begin
                    n_state = nnc_pkg::S_DONE;
                end
            end
            nnc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = nnc_pkg::S_IDLE;
                end
            end
            default: n_state = nnc_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_ready        = 1'b0;
        scan_ctl.clear = 1'b0;
        scan_ctl.rd_en = 1'b0;
        merge_start    = 1'b0;
        ld_out         = 1'b0;
        unique case (r_state)
            nnc_pkg::S_IDLE: begin
                o_ready        = 1'b1;
                // ready is high here, so valid alone marks the transaction
                scan_ctl.clear = i_valid && is_classify;
            end
            nnc_pkg::S_SCAN: begin
                scan_ctl.rd_en = 1'b1;
            end
            nnc_pkg::S_DRAIN: begin
                merge_start = r_drain;
            end
            nnc_pkg::S_MERGE: begin
            end
            nnc_pkg::S_DONE: begin
                ld_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // lanes and merge
    // ------------------------------------------------------------------
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        nnc_lane #(
            .FEATURE_BITS (FEATURE_BITS),
            .LANE_BITS    (LANE_BITS),
            .LANE_ID      (l),
            .ROW_DEPTH    (ROW_DEPTH),
            .ROW_BITS     (ROW_BITS),
            .CNT_BITS     (CNT_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (scan_ctl),
            .i_rd_row  (r_row),
            .i_count   (r_count),
            .i_query   (r_query),
            .i_wr_en   (wr_en && (wr_lane == LANE_BITS'(l))),
            .i_wr_row  (wr_row),
            .i_wr_data (wr_word),
            .o_found   (lane_found[l]),
            .o_dist    (lane_dist[l]),
            .o_row     (lane_row[l]),
            .o_label   (lane_label[l])
        );
    end

    nnc_merge #(
        .FEATURE_BITS (FEATURE_BITS),
        .LANE_BITS    (LANE_BITS),
        .ROW_BITS     (ROW_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (merge_start),
        .i_found (lane_found),
        .i_dist  (lane_dist),
        .i_row   (lane_row),
        .i_label (lane_label),
        .o_done  (merge_done),
        .o_dist  (best_dist),
        .o_label (best_label)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    assign hit      = !r_qempty && (best_label == r_qlabel);
    assign dist_ext = (DIST_BITS + nnc_pkg::OUT_DIST_BITS)'(best_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nnc_pkg::S_IDLE;
            r_count     <= '0;
            r_correct   <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_count <= r_count + 1'b1;
            end else if (accept && is_clear) begin
                r_count   <= '0;
                r_correct <= '0;
            end
            if (r_state == nnc_pkg::S_DRAIN) begin
                r_drain <= !r_drain;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
                if (hit && (r_correct != nnc_pkg::COUNT_MAX)) begin
                    r_correct <= r_correct + 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // query capture
        if (accept && is_classify) begin
            r_query    <= {i_feature_d, i_feature_c, i_feature_b, i_feature_a};
            r_qlabel   <= i_label;
            r_qempty   <= (r_count == '0);
            r_last_row <= last_idx[LANE_BITS +: ROW_BITS];
            r_row      <= '0;
        end else if (scan_ctl.rd_en) begin
            r_row <= r_row + 1'b1;
        end

        // result payload
        if (ld_out) begin
            r_empty <= r_qempty;
            r_hit   <= hit;
            r_pred  <= r_qempty ? '0 : best_label;
            r_dist  <= r_qempty ? '0 : dist_ext[nnc_pkg::OUT_DIST_BITS-1:0];
            r_total <= (hit && (r_correct != nnc_pkg::COUNT_MAX))
                     ? r_correct + 1'b1 : r_correct;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_predicted_class = r_pred;
    assign o_is_correct      = r_hit;
    assign o_store_empty     = r_empty;
    assign o_min_distance_sq = r_dist;
    assign o_correct_total   = r_total;

endmodule

[hdl/nnc_checker.sv]
// ============================================================================
// nnc_checker: port-level checks for the classifier
// Result consistency and request flow control, bound to the top level.
// ============================================================================
module nnc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic [nnc_pkg::OPC_BITS-1:0]      i_opcode,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [nnc_pkg::LABEL_BITS-1:0]    o_predicted_class,
    input logic                              o_is_correct,
    input logic                              o_store_empty,
    input logic [nnc_pkg::OUT_DIST_BITS-1:0] o_min_distance_sq,
    input logic [nnc_pkg::COUNT_BITS-1:0]    o_correct_total
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_predicted_class)
            && $stable(o_is_correct) && $stable(o_store_empty)
            && $stable(o_min_distance_sq) && $stable(o_correct_total)))
        else $error("result changed while stalled");

    // empty store gives an all-zero answer
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_store_empty) |->
            (o_predicted_class == '0 && !o_is_correct && o_min_distance_sq == '0))
        else $error("empty-store result not zero");

    // a hit has been counted
    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_correct) |-> (o_correct_total != '0 && !o_store_empty))
        else $error("hit without count");

    // a classify transaction occupies the block
    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_opcode == nnc_pkg::OP_CLASSIFY) |=> !o_ready)
        else $error("request taken during a search");

endmodule

bind nearest_neighbour_classifier_top nnc_checker u_nnc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .i_opcode          (i_opcode),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_predicted_class (o_predicted_class),
    .o_is_correct      (o_is_correct),
    .o_store_empty     (o_store_empty),
    .o_min_distance_sq (o_min_distance_sq),
    .o_correct_total   (o_correct_total)
);

[tb/sv/testbench.sv]
// ============================================================================
// testbench: self-checking bench for nearest_neighbour_classifier_top
// Sends load, classify, clear and unused-opcode transactions with random
// idling on both handshakes. A behavioral nearest-match predictor computes
// every classify verdict, and each returned result is compared in order.
// ============================================================================
module testbench;

    localparam int STORE_DEPTH      = 64;
    localparam int FEATURE_BITS     = 8;
    localparam int FEAT_TOP         = (1 << FEATURE_BITS) - 1;
    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_ITEMS     = 1000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 64;     // well above a full-store search
    localparam int TAIL_LOADS       = 8;      // samples stored for the last part
    localparam int TAIL_QUERIES     = 48;     // back-to-back classifies at the end
    localparam int MAX_REPORTS      = 10;
    localparam int LIMIT_TIME       = 40_000_000;
    localparam int DIRECTED_COUNT   = 22;

    localparam int NF  = nnc_pkg::NUM_FEATURES;
    localparam int OPB = nnc_pkg::OPC_BITS;
    localparam int LBB = nnc_pkg::LABEL_BITS;
    localparam int ODB = nnc_pkg::OUT_DIST_BITS;
    localparam int CTB = nnc_pkg::COUNT_BITS;

    localparam logic [OPB-1:0] OP_UNUSED = 2'd3;
    localparam logic [ODB-1:0] DIST_FULL = 18'd260100;

    typedef logic [NF-1:0][FEATURE_BITS-1:0] t_feat_vec;

    // one classify result, field order matches the port list
    typedef struct packed {
        logic [LBB-1:0] predicted_class;
        logic           is_correct;
        logic           store_empty;
        logic [ODB-1:0] min_distance_sq;
        logic [CTB-1:0] correct_total;
    } t_verdict;

    // one row of the directed table; typed rows carry their verdict inline
    typedef struct packed {
        logic [OPB-1:0] opcode;
        t_feat_vec      feats;
        logic [LBB-1:0] label;
        logic           typed;
        t_verdict       due;
    } t_stim_row;

    localparam t_feat_vec F_ZERO  = '0;
    localparam t_feat_vec F_MAX   = '1;
    localparam t_verdict  UNTYPED = '0;

    // ------------------------------------------------------------------------
    // DUT ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_ready;
    logic [OPB-1:0]           i_opcode    = '0;
    logic [FEATURE_BITS-1:0]  i_feature_a = '0;
    logic [FEATURE_BITS-1:0]  i_feature_b = '0;
    logic [FEATURE_BITS-1:0]  i_feature_c = '0;
    logic [FEATURE_BITS-1:0]  i_feature_d = '0;
    logic [LBB-1:0]           i_label     = '0;
    logic                     o_valid;
    logic                     i_ready     = 1'b0;
    logic [LBB-1:0]           o_predicted_class;
    logic                     o_is_correct;
    logic                     o_store_empty;
    logic [ODB-1:0]           o_min_distance_sq;
    logic [CTB-1:0]           o_correct_total;

    nearest_neighbour_classifier_top #(
        .STORE_DEPTH  (STORE_DEPTH),
        .FEATURE_BITS (FEATURE_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_feature_a       (i_feature_a),
        .i_feature_b       (i_feature_b),
        .i_feature_c       (i_feature_c),
        .i_feature_d       (i_feature_d),
        .i_label           (i_label),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_predicted_class (o_predicted_class),
        .o_is_correct      (o_is_correct),
        .o_store_empty     (o_store_empty),
        .o_min_distance_sq (o_min_distance_sq),
        .o_correct_total   (o_correct_total)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the sample store and hit counter
    // ------------------------------------------------------------------------
    t_feat_vec             kept_feat  [STORE_DEPTH];
    logic [LBB-1:0]        kept_label [STORE_DEPTH];
    int                    kept_count = 0;
    logic [CTB-1:0]        hit_count  = '0;
    t_verdict              due_verdicts [$];   // classify verdicts still owed
    int                    live_items = 0;     // transactions that change state or answer

    int       mismatch_count = 0;
    bit       idle_on        = 1'b1;
    int       hold_asked     = 0;   // bumped by the stimulus for a long receiver hold
    int       hold_served    = 0;
    int       hold_left      = 0;
    int       stall_left     = 0;
    t_verdict seen_verdict;
    t_verdict owed_verdict;

    t_stim_row directed_rows [DIRECTED_COUNT];

    // Update the predictor for one accepted transaction. A classify always
    // owes a verdict; typed rows queue their hand-written value instead of
    // the computed one, but the counter still follows the computation.
    task automatic nearest_match_predict(input logic [OPB-1:0] opcode,
                                         input t_feat_vec      feats,
                                         input logic [LBB-1:0] lbl,
                                         input logic           typed,
                                         input t_verdict       typed_verdict);
        t_verdict              outcome;
        int unsigned           best_dist;
        int unsigned           sample_dist;
        int                    diff;
        logic [LBB-1:0]        best_label;
        case (opcode)
            nnc_pkg::OP_LOAD: begin
                // a full store drops the sample
                if (kept_count < STORE_DEPTH) begin
                    kept_feat[kept_count]  = feats;
                    kept_label[kept_count] = lbl;
                    kept_count++;
                    live_items++;
                end
            end
            nnc_pkg::OP_CLEAR: begin
                kept_count = 0;
                hit_count  = '0;
                live_items++;
            end
            nnc_pkg::OP_CLASSIFY: begin
                live_items++;
                outcome = '0;
                if (kept_count == 0) begin
                    // empty store: flag it, label and distance stay zero
                    outcome.store_empty = 1'b1;
                end else begin
                    best_dist  = 0;
                    best_label = '0;
                    for (int n = 0; n < kept_count; n++) begin
                        sample_dist = 0;
                        for (int k = 0; k < NF; k++) begin
                            diff = int'(feats[k]) - int'(kept_feat[n][k]);
                            sample_dist += diff * diff;
                        end
                        // strict less-than: the earliest sample keeps a tie
                        if (n == 0 || sample_dist < best_dist) begin
                            best_dist  = sample_dist;
                            best_label = kept_label[n];
                        end
                    end
                    outcome.predicted_class = best_label;
                    outcome.is_correct      = (best_label == lbl);
                    outcome.min_distance_sq = best_dist[ODB-1:0];
                    // the hit counter sticks at its top value
                    if (outcome.is_correct && hit_count != nnc_pkg::COUNT_MAX)
                        hit_count++;
                end
                outcome.correct_total = hit_count;
                due_verdicts.push_back(typed ? typed_verdict : outcome);
            end
            default: ;   // unused opcode: no result, no state change
        endcase
    endtask

    function automatic t_feat_vec pick_feats(input logic narrow);
        t_feat_vec f;
        for (int k = 0; k < NF; k++) begin
            if (narrow) begin
                // tiny range, so distances collide and ties are common
                f[k] = FEATURE_BITS'($urandom_range(0, 3));
            end else begin
                case ($urandom_range(0, 9))
                    0:       f[k] = '0;
                    1:       f[k] = '1;
                    default: f[k] = FEATURE_BITS'($urandom_range(0, FEAT_TOP));
                endcase
            end
        end
        return f;
    endfunction

    // a query close to a stored sample, each feature nudged by at most two
    function automatic t_feat_vec near_feats(input int idx);
        t_feat_vec f;
        int        v;
        f = kept_feat[idx];
        for (int k = 0; k < NF; k++) begin
            v = int'(f[k]) + int'($urandom_range(0, 4)) - 2;
            if (v < 0)
                v = 0;
            if (v > FEAT_TOP)
                v = FEAT_TOP;
            f[k] = v[FEATURE_BITS-1:0];
        end
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Payload changes at the falling edge; the transaction is
    // taken at the first rising edge with o_ready high. Valid stays high
    // after acceptance, so back-to-back transactions see no low gap on it.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [OPB-1:0] opcode,
                             input t_feat_vec      feats,
                             input logic [LBB-1:0] lbl,
                             input logic           typed,
                             input t_verdict       typed_verdict);
        int gap;
        gap = (idle_on && $urandom_range(0, 6) == 0) ? int'($urandom_range(1, 17)) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            // idle burst; junk on the payload must be ignored
            i_valid     <= 1'b0;
            i_opcode    <= OPB'($urandom);
            i_feature_a <= FEATURE_BITS'($urandom);
            i_feature_b <= FEATURE_BITS'($urandom);
            i_feature_c <= FEATURE_BITS'($urandom);
            i_feature_d <= FEATURE_BITS'($urandom);
            i_label     <= LBB'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= opcode;
        i_feature_a <= feats[0];
        i_feature_b <= feats[1];
        i_feature_c <= feats[2];
        i_feature_d <= feats[3];
        i_label     <= lbl;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        nearest_match_predict(opcode, feats, lbl, typed, typed_verdict);
    endtask

    task automatic send_plain(input logic [OPB-1:0] opcode,
                              input t_feat_vec      feats,
                              input logic [LBB-1:0] lbl);
        send_item(opcode, feats, lbl, 1'b0, UNTYPED);
    endtask

    // drop valid and wait until every owed verdict has come back
    task automatic pause_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (due_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, plus a long hold when asked for.
    // The hold is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (idle_on && stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest owed verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            seen_verdict = '{o_predicted_class, o_is_correct, o_store_empty,
                             o_min_distance_sq, o_correct_total};
            if (due_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: class %0d hit %0d empty %0d dist %0d total %0d",
                             seen_verdict.predicted_class, seen_verdict.is_correct,
                             seen_verdict.store_empty, seen_verdict.min_distance_sq,
                             seen_verdict.correct_total);
            end else begin
                owed_verdict = due_verdicts.pop_front();
                if (seen_verdict !== owed_verdict) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: exp class %0d hit %0d empty %0d dist %0d total %0d",
                                 owed_verdict.predicted_class, owed_verdict.is_correct,
                                 owed_verdict.store_empty, owed_verdict.min_distance_sq,
                                 owed_verdict.correct_total);
                        $display("          got class %0d hit %0d empty %0d dist %0d total %0d",
                                 seen_verdict.predicted_class, seen_verdict.is_correct,
                                 seen_verdict.store_empty, seen_verdict.min_distance_sq,
                                 seen_verdict.correct_total);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int                    seq_no;
        int                    n_load;
        int                    n_query;
        int                    idx;
        logic                  narrow;
        logic                  hold_seq;
        logic [LBB-1:0]        q_label;
        t_feat_vec             q_feats;

        directed_rows = '{
            // right after reset the store is empty
            '{nnc_pkg::OP_CLASSIFY, F_ZERO, 2'd0, 1'b1, '{2'd0, 1'b0, 1'b1, 18'd0, 16'd0}},
            // unused opcode leaves no trace
            '{OP_UNUSED,            F_MAX,  2'd3, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLEAR,    F_ZERO, 2'd0, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, F_MAX,  2'd3, 1'b1, '{2'd0, 1'b0, 1'b1, 18'd0, 16'd0}},
            '{nnc_pkg::OP_LOAD,     F_ZERO, 2'd0, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, F_ZERO, 2'd0, 1'b1, '{2'd0, 1'b1, 1'b0, 18'd0, 16'd1}},
            // farthest possible query gives the largest distance
            '{nnc_pkg::OP_CLASSIFY, F_MAX,  2'd1, 1'b1,
              '{2'd0, 1'b0, 1'b0, DIST_FULL, 16'd1}},
            '{nnc_pkg::OP_LOAD,     F_MAX,  2'd3, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, F_MAX,  2'd3, 1'b1, '{2'd3, 1'b1, 1'b0, 18'd0, 16'd2}},
            // duplicate of the first sample: the earlier entry wins the tie
            '{nnc_pkg::OP_LOAD,     F_ZERO, 2'd2, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, F_ZERO, 2'd2, 1'b1, '{2'd0, 1'b0, 1'b0, 18'd0, 16'd2}},
            '{nnc_pkg::OP_LOAD,     32'h0000_00FF, 2'd1, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, 32'h0000_007F, 2'd0, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, 32'hFF00_00FF, 2'd1, 1'b0, UNTYPED},
            '{nnc_pkg::OP_LOAD,     32'hAA55_AA55, 2'd2, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, 32'h55AA_55AA, 2'd0, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, 32'hFF00_0000, 2'd1, 1'b0, UNTYPED},
            '{OP_UNUSED,            F_ZERO, 2'd0, 1'b0, UNTYPED},
            // clear empties the store and the hit count
            '{nnc_pkg::OP_CLEAR,    F_MAX,  2'd3, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, 32'h1234_5678, 2'd2, 1'b1,
              '{2'd0, 1'b0, 1'b1, 18'd0, 16'd0}},
            '{nnc_pkg::OP_LOAD,     32'h0102_0304, 2'd1, 1'b0, UNTYPED},
            '{nnc_pkg::OP_CLASSIFY, 32'h0102_0304, 2'd1, 1'b1,
              '{2'd1, 1'b1, 1'b0, 18'd0, 16'd1}}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[r])
            send_item(directed_rows[r].opcode, directed_rows[r].feats,
                      directed_rows[r].label, directed_rows[r].typed,
                      directed_rows[r].due);
        pause_until_drained();

        // Random part: mostly clear/load/classify sequences with random
        // content, some noise transactions in between.
        live_items = 0;
        seq_no     = 0;
        while (live_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_plain(OPB'($urandom_range(0, 3)), pick_feats(1'b0),
                               LBB'($urandom));
            end else begin
                if ($urandom_range(0, 4) != 0)
                    send_plain(nnc_pkg::OP_CLEAR, pick_feats(1'b0), LBB'($urandom));
                case ($urandom_range(0, 9))
                    0:       n_load = $urandom_range(STORE_DEPTH, STORE_DEPTH + 6);
                    1, 2:    n_load = $urandom_range(13, STORE_DEPTH - 1);
                    3:       n_load = 0;
                    default: n_load = $urandom_range(1, 12);
                endcase
                narrow = ($urandom_range(0, 3) == 0);
                repeat (n_load)
                    send_plain(nnc_pkg::OP_LOAD, pick_feats(narrow), LBB'($urandom));

                // a couple of sequences run against a long receiver hold,
                // so finished verdicts back up and the request side stalls
                hold_seq = (seq_no == 3 || seq_no == 40);
                n_query  = hold_seq ? 16 : $urandom_range(1, 12);
                if (hold_seq)
                    hold_asked++;
                repeat (n_query) begin
                    if (kept_count > 0 && $urandom_range(0, 2) != 0) begin
                        idx     = $urandom_range(0, kept_count - 1);
                        q_feats = near_feats(idx);
                        q_label = ($urandom_range(0, 1) == 0) ? kept_label[idx]
                                                              : LBB'($urandom);
                    end else begin
                        q_feats = pick_feats(narrow);
                        q_label = LBB'($urandom);
                    end
                    send_plain(nnc_pkg::OP_CLASSIFY, q_feats, q_label);
                end
            end
            if (seq_no == 5 || $urandom_range(0, 7) == 0)
                pause_until_drained();
            seq_no++;
        end
        pause_until_drained();

        // Last part, no idling: a small store and back-to-back queries,
        // half of them near a stored sample with its label.
        idle_on = 1'b0;
        send_plain(nnc_pkg::OP_CLEAR, pick_feats(1'b0), LBB'($urandom));
        repeat (TAIL_LOADS)
            send_plain(nnc_pkg::OP_LOAD, pick_feats(1'b0), LBB'($urandom));
        for (int q = 0; q < TAIL_QUERIES; q++) begin
            if (q % 2 == 0) begin
                idx     = $urandom_range(0, kept_count - 1);
                q_feats = near_feats(idx);
                q_label = kept_label[idx];
            end else begin
                q_feats = pick_feats(1'b0);
                q_label = LBB'($urandom);
            end
            send_plain(nnc_pkg::OP_CLASSIFY, q_feats, q_label);
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && due_verdicts.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // hang guard
    initial begin
        #LIMIT_TIME;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
hdl/nnc_pkg.sv
hdl/nnc_ram.sv
hdl/nnc_lane.sv
hdl/nnc_merge.sv
hdl/nearest_neighbour_classifier_top.sv
hdl/nnc_checker.sv
tb/sv/testbench.sv
